[rtl/rau_pkg.sv]
`default_nettype none

package rau_pkg;

  localparam int unsigned OPERAND_BITS_DEF = 12;
  localparam int unsigned DW               = 64;  // internal datapath width
  localparam int unsigned OUT_NUM_W        = 49;
  localparam int unsigned OUT_DEN_W        = 35;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } rau_op_e;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] dividend;
    logic [DW-1:0] divisor;
  } rau_div_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] quot;
    logic [DW-1:0] rem;
  } rau_div_rsp_t;

endpackage

`default_nettype wire

[rtl/rau_div.sv]
`default_nettype none

// Unsigned restoring divider, one quotient bit per cycle.
module rau_div
  import rau_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire rau_div_req_t req_i,
  output rau_div_rsp_t      rsp_o
);

  localparam int unsigned CW = $clog2(DW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!diff[DW]) begin
        rem_d = diff[DW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without a running division");
  a_nonzero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> req_i.divisor != '0) else $error("division by zero issued");

endmodule

`default_nettype wire

[rtl/rational_arithmetic_unit.sv]
// Every division runs on the shared divider; add/sub needs gcd steps + 2
//   divisions, reduction needs gcd steps + 2 divisions, mixed form 1 division.
// Throughput: one item at a time; in_ready_o is high only while idle.
// A finished result sits in the output register while the next item runs.
// Reset (rst_ni, async, active low) returns the sequencer to idle, clears out_valid_o.
`default_nettype none

module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int unsigned OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     req_type_i,
  input  wire logic signed [OPERAND_BITS-1:0] a_whole_i,
  input  wire logic signed [OPERAND_BITS-1:0] a_numerator_i,
  input  wire logic [OPERAND_BITS-2:0]        a_denominator_i,
  input  wire logic signed [OPERAND_BITS-1:0] b_whole_i,
  input  wire logic signed [OPERAND_BITS-1:0] b_numerator_i,
  input  wire logic [OPERAND_BITS-2:0]        b_denominator_i,
  input  wire logic                           do_reduce_i,
  input  wire logic                           make_mixed_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [OUT_NUM_W-1:0]         result_whole_o,
  output logic signed [OUT_NUM_W-1:0]         result_numerator_o,
  output logic [OUT_DEN_W-1:0]                result_denominator_o,
  output logic                                divide_by_zero_o
);

  // Improper numerators fit 2*OPERAND_BITS signed bits; the shared
  // multiplier takes one extra bit so magnitudes stay positive.
  localparam int unsigned AW = 2 * OPERAND_BITS;
  localparam int unsigned MW = AW + 1;
  localparam int unsigned DEN_W = OPERAND_BITS - 1;

  // Sequencer state codes
  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_GCD   = 5'd1;   // one Euclid step or exit
  localparam logic [4:0] ST_DWAIT = 5'd2;   // wait for the divider
  localparam logic [4:0] ST_GSTEP = 5'd3;   // x <= y, y <= x mod y
  localparam logic [4:0] ST_AS1   = 5'd4;
  localparam logic [4:0] ST_AS2   = 5'd5;
  localparam logic [4:0] ST_AS3   = 5'd6;
  localparam logic [4:0] ST_AS4   = 5'd7;
  localparam logic [4:0] ST_AS5   = 5'd8;
  localparam logic [4:0] ST_M1    = 5'd9;
  localparam logic [4:0] ST_M2    = 5'd10;
  localparam logic [4:0] ST_D1    = 5'd11;
  localparam logic [4:0] ST_D2    = 5'd12;
  localparam logic [4:0] ST_RED   = 5'd13;
  localparam logic [4:0] ST_R1    = 5'd14;
  localparam logic [4:0] ST_R2    = 5'd15;
  localparam logic [4:0] ST_R3    = 5'd16;
  localparam logic [4:0] ST_MIX   = 5'd17;
  localparam logic [4:0] ST_MX2   = 5'd18;
  localparam logic [4:0] ST_OUT   = 5'd19;

  logic [4:0] state_q, state_d;
  logic [4:0] gret_q, gret_d;   // where the gcd loop returns to
  logic [4:0] dret_q, dret_d;   // where a single division returns to
  logic       out_valid_q, out_valid_d;

  logic [1:0]           op_q, op_d;
  logic                 red_q, red_d;
  logic                 mix_q, mix_d;
  logic                 dbz_q, dbz_d;
  logic [DEN_W-1:0]     ad_q, ad_d, bd_q, bd_d;
  logic signed [AW-1:0] an_q, an_d, bn_q, bn_d;
  logic [DEN_W-1:0]     t1_q, t1_d;   // ad / gcd
  logic signed [DW-1:0] tmp_q, tmp_d;
  logic signed [DW-1:0] num_q, num_d;
  logic [DW-1:0]        den_q, den_d;
  logic signed [DW-1:0] whole_q, whole_d;
  logic [DW-1:0]        gx_q, gx_d, gy_q, gy_d;

  logic signed [OUT_NUM_W-1:0] res_whole_q, res_whole_d;
  logic signed [OUT_NUM_W-1:0] res_num_q, res_num_d;
  logic [OUT_DEN_W-1:0]        res_den_q, res_den_d;
  logic                        res_dbz_q, res_dbz_d;

  // Operand loading: zero denominators read as one, then make improper
  logic [DEN_W-1:0]     ad_ld, bd_ld;
  logic signed [AW-1:0] an_ld, bn_ld;

  assign ad_ld = (a_denominator_i == '0) ? DEN_W'(1) : a_denominator_i;
  assign bd_ld = (b_denominator_i == '0) ? DEN_W'(1) : b_denominator_i;
  assign an_ld = AW'(a_whole_i) * $signed(AW'(ad_ld)) + AW'(a_numerator_i);
  assign bn_ld = AW'(b_whole_i) * $signed(AW'(bd_ld)) + AW'(b_numerator_i);

  // Shared multiplier, result always lands in a register
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] mul_full;
  logic signed [DW-1:0]   mul_p;

  assign mul_full = mul_a * mul_b;
  assign mul_p    = DW'(mul_full);

  // Shared divider
  rau_div_req_t div_req;
  rau_div_rsp_t div_rsp;

  rau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic          num_neg;
  logic [DW-1:0] num_mag;

  assign num_neg = num_q[DW-1];
  assign num_mag = num_neg ? DW'(-num_q) : DW'(num_q);

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    gret_d      = gret_q;
    dret_d      = dret_q;
    out_valid_d = out_valid_q;
    op_d        = op_q;
    red_d       = red_q;
    mix_d       = mix_q;
    dbz_d       = dbz_q;
    ad_d        = ad_q;
    bd_d        = bd_q;
    an_d        = an_q;
    bn_d        = bn_q;
    t1_d        = t1_q;
    tmp_d       = tmp_q;
    num_d       = num_q;
    den_d       = den_q;
    whole_d     = whole_q;
    gx_d        = gx_q;
    gy_d        = gy_q;
    res_whole_d = res_whole_q;
    res_num_d   = res_num_q;
    res_den_d   = res_den_q;
    res_dbz_d   = res_dbz_q;
    div_req     = '0;
    mul_a       = '0;
    mul_b       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = req_type_i;
          red_d   = do_reduce_i;
          mix_d   = make_mixed_i;
          ad_d    = ad_ld;
          bd_d    = bd_ld;
          an_d    = an_ld;
          bn_d    = bn_ld;
          dbz_d   = 1'b0;
          whole_d = '0;
          case (rau_op_e'(req_type_i))
            OP_ADD, OP_SUB: begin
              gx_d    = DW'(ad_ld);
              gy_d    = DW'(bd_ld);
              gret_d  = ST_AS1;
              state_d = ST_GCD;
            end
            OP_MUL: state_d = ST_M1;
            OP_DIV: begin
              if (bn_ld == '0) begin
                // dividing by a zero fraction: all-zero result, flag set
                dbz_d   = 1'b1;
                num_d   = '0;
                den_d   = '0;
                state_d = ST_OUT;
              end else begin
                state_d = ST_D1;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_GCD: begin
        if (gy_q == '0) begin
          state_d = gret_q;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = gx_q;
          div_req.divisor  = gy_q;
          dret_d           = ST_GSTEP;
          state_d          = ST_DWAIT;
        end
      end
      ST_DWAIT: begin
        if (div_rsp.done) begin
          state_d = dret_q;
        end
      end
      ST_GSTEP: begin
        gx_d    = gy_q;
        gy_d    = div_rsp.rem;
        state_d = ST_GCD;
      end
      // add / subtract on the lcm of the denominators
      ST_AS1: begin
        div_req.start    = 1'b1;
        div_req.dividend = DW'(ad_q);
        div_req.divisor  = gx_q;
        dret_d           = ST_AS2;
        state_d          = ST_DWAIT;
      end
      ST_AS2: begin
        t1_d             = div_rsp.quot[DEN_W-1:0];
        div_req.start    = 1'b1;
        div_req.dividend = DW'(bd_q);
        div_req.divisor  = gx_q;
        dret_d           = ST_AS3;
        state_d          = ST_DWAIT;
      end
      ST_AS3: begin
        mul_a   = MW'(an_q);
        mul_b   = $signed(MW'(div_rsp.quot[DEN_W-1:0]));
        num_d   = mul_p;
        state_d = ST_AS4;
      end
      ST_AS4: begin
        mul_a   = MW'(bn_q);
        mul_b   = $signed(MW'(t1_q));
        tmp_d   = mul_p;
        state_d = ST_AS5;
      end
      ST_AS5: begin
        num_d   = (rau_op_e'(op_q) == OP_SUB) ? num_q - tmp_q : num_q + tmp_q;
        mul_a   = $signed(MW'(t1_q));
        mul_b   = $signed(MW'(bd_q));
        den_d   = DW'(mul_p);
        state_d = ST_RED;
      end
      ST_M1: begin
        mul_a   = MW'(an_q);
        mul_b   = MW'(bn_q);
        num_d   = mul_p;
        state_d = ST_M2;
      end
      ST_M2: begin
        mul_a   = $signed(MW'(ad_q));
        mul_b   = $signed(MW'(bd_q));
        den_d   = DW'(mul_p);
        state_d = ST_RED;
      end
      ST_D1: begin
        mul_a   = MW'(an_q);
        mul_b   = $signed(MW'(bd_q));
        num_d   = mul_p;
        state_d = ST_D2;
      end
      ST_D2: begin
        // divisor sign moves into the numerator
        mul_a   = $signed(MW'(ad_q));
        mul_b   = bn_q[AW-1] ? -MW'(bn_q) : MW'(bn_q);
        den_d   = DW'(mul_p);
        num_d   = bn_q[AW-1] ? -num_q : num_q;
        state_d = ST_RED;
      end
      ST_RED: begin
        if (red_q) begin
          gx_d    = num_mag;
          gy_d    = den_q;
          gret_d  = ST_R1;
          state_d = ST_GCD;
        end else begin
          state_d = ST_MIX;
        end
      end
      ST_R1: begin
        div_req.start    = 1'b1;
        div_req.dividend = num_mag;
        div_req.divisor  = gx_q;
        dret_d           = ST_R2;
        state_d          = ST_DWAIT;
      end
      ST_R2: begin
        num_d            = num_neg ? -$signed(div_rsp.quot) : $signed(div_rsp.quot);
        div_req.start    = 1'b1;
        div_req.dividend = den_q;
        div_req.divisor  = gx_q;
        dret_d           = ST_R3;
        state_d          = ST_DWAIT;
      end
      ST_R3: begin
        den_d   = div_rsp.quot;
        state_d = ST_MIX;
      end
      ST_MIX: begin
        if (mix_q) begin
          div_req.start    = 1'b1;
          div_req.dividend = num_mag;
          div_req.divisor  = den_q;
          dret_d           = ST_MX2;
          state_d          = ST_DWAIT;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_MX2: begin
        // truncation toward zero: both parts take the numerator's sign
        whole_d = num_neg ? -$signed(div_rsp.quot) : $signed(div_rsp.quot);
        num_d   = num_neg ? -$signed(div_rsp.rem) : $signed(div_rsp.rem);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          res_whole_d = whole_q[OUT_NUM_W-1:0];
          res_num_d   = num_q[OUT_NUM_W-1:0];
          res_den_d   = den_q[OUT_DEN_W-1:0];
          res_dbz_d   = dbz_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gret_q      <= ST_IDLE;
      dret_q      <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gret_q      <= gret_d;
      dret_q      <= dret_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    red_q       <= red_d;
    mix_q       <= mix_d;
    dbz_q       <= dbz_d;
    ad_q        <= ad_d;
    bd_q        <= bd_d;
    an_q        <= an_d;
    bn_q        <= bn_d;
    t1_q        <= t1_d;
    tmp_q       <= tmp_d;
    num_q       <= num_d;
    den_q       <= den_d;
    whole_q     <= whole_d;
    gx_q        <= gx_d;
    gy_q        <= gy_d;
    res_whole_q <= res_whole_d;
    res_num_q   <= res_num_d;
    res_den_q   <= res_den_d;
    res_dbz_q   <= res_dbz_d;
  end

  assign out_valid_o          = out_valid_q;
  assign result_whole_o       = res_whole_q;
  assign result_numerator_o   = res_num_q;
  assign result_denominator_o = res_den_q;
  assign divide_by_zero_o     = res_dbz_q;

  a_dbz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |->
      result_numerator_o == '0 && result_denominator_o == '0 && result_whole_o == '0)
    else $error("divide-by-zero transfer carries a non-zero value");
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !divide_by_zero_o |-> result_denominator_o != '0)
    else $error("zero denominator on a normal result");
  a_wait_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DWAIT && !div_rsp.done |=> state_q == ST_DWAIT)
    else $error("left divider wait before done");

endmodule

`default_nettype wire

[test/rational_arithmetic_unit_tb.sv]
`default_nettype none

module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OB         = OPERAND_BITS_DEF;
  localparam int unsigned N_RANDOM   = 2000;
  localparam int unsigned N_CALM     = 200;    // tail of the run without idling
  localparam int unsigned HOLD_LEN   = 20000;  // long receiver hold-off
  localparam int unsigned DRAIN_WAIT = 200;
  localparam int unsigned STUCK_MAX  = 200000; // cycles without any transfer

  // One operand pair plus operation and post-processing flags.
  typedef struct packed {
    rau_op_e                op;
    logic signed [OB-1:0]   a_whole;
    logic signed [OB-1:0]   a_num;
    logic [OB-2:0]          a_den;
    logic signed [OB-1:0]   b_whole;
    logic signed [OB-1:0]   b_num;
    logic [OB-2:0]          b_den;
    logic                   reduce;
    logic                   mixed;
  } frac_req_t;

  typedef struct packed {
    logic signed [OUT_NUM_W-1:0] whole;
    logic signed [OUT_NUM_W-1:0] num;
    logic [OUT_DEN_W-1:0]        den;
    logic                        dbz;
  } frac_res_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [1:0]                  req_type_i;
  logic signed [OB-1:0]        a_whole_i;
  logic signed [OB-1:0]        a_numerator_i;
  logic [OB-2:0]               a_denominator_i;
  logic signed [OB-1:0]        b_whole_i;
  logic signed [OB-1:0]        b_numerator_i;
  logic [OB-2:0]               b_denominator_i;
  logic                        do_reduce_i;
  logic                        make_mixed_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic signed [OUT_NUM_W-1:0] result_whole_o;
  logic signed [OUT_NUM_W-1:0] result_numerator_o;
  logic [OUT_DEN_W-1:0]        result_denominator_o;
  logic                        divide_by_zero_o;

  rational_arithmetic_unit #(.OPERAND_BITS(OB)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i,
    .a_whole_i, .a_numerator_i, .a_denominator_i,
    .b_whole_i, .b_numerator_i, .b_denominator_i,
    .do_reduce_i, .make_mixed_i, .out_valid_o, .out_ready_i,
    .result_whole_o, .result_numerator_o, .result_denominator_o, .divide_by_zero_o
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: improper fractions, lcm-based add/sub, cross-multiplied mul/div,
  // optional gcd reduction and optional truncating split into a mixed fraction.
  // All intermediate values fit comfortably in 64 bits at these widths.
  // ---------------------------------------------------------------------------
  function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_res_t fraction_result(frac_req_t r);
    longint ad, bd, an, bn, num, den, whole, cd;
    longint unsigned g, mnum;
    frac_res_t o;
    o = '0;
    whole = 0;
    // a zero denominator reads as one
    ad = (r.a_den == 0) ? 64'sd1 : longint'({1'b0, r.a_den});
    bd = (r.b_den == 0) ? 64'sd1 : longint'({1'b0, r.b_den});
    an = longint'(r.a_whole) * ad + longint'(r.a_num);
    bn = longint'(r.b_whole) * bd + longint'(r.b_num);
    case (r.op)
      OP_ADD, OP_SUB: begin
        g   = euclid_gcd(ad, bd);
        cd  = longint'((unsigned'(ad) / g) * unsigned'(bd));
        num = (r.op == OP_ADD) ? an * (cd / ad) + bn * (cd / bd)
                               : an * (cd / ad) - bn * (cd / bd);
        den = cd;
      end
      OP_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      default: begin
        if (bn == 0) begin
          o.dbz = 1'b1;
          return o;
        end
        // divisor sign moves into the numerator
        num = an * bd;
        den = ad * ((bn < 0) ? -bn : bn);
        if (bn < 0) num = -num;
      end
    endcase
    if (r.reduce) begin
      mnum = (num < 0) ? unsigned'(-num) : unsigned'(num);
      g    = euclid_gcd(mnum, den);
      if (g != 0) begin
        num = (num < 0) ? -longint'(mnum / g) : longint'(mnum / g);
        den = longint'(unsigned'(den) / g);
      end
    end
    if (r.mixed) begin
      whole = num / den;   // truncates toward zero
      num   = num % den;
    end
    o.whole = whole[OUT_NUM_W-1:0];
    o.num   = num[OUT_NUM_W-1:0];
    o.den   = den[OUT_DEN_W-1:0];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver side
  // ---------------------------------------------------------------------------
  frac_res_t pending_results[$];  // results owed by the block, oldest first
  logic      row_fixed;           // current item carries a typed-in answer
  frac_res_t row_answer;
  bit        calm;                // no idling on either side
  bit        hold_req;            // ask the receiver for a long hold-off
  int        n_errors;

  // directed rows
  frac_req_t table_req[$];
  bit        table_fixed[$];
  frac_res_t table_ans[$];

  task automatic add_row(frac_req_t r, bit fixed = 1'b0, frac_res_t answer = '0);
    table_req.insert(table_req.size(), r);
    table_fixed.insert(table_fixed.size(), fixed);
    table_ans.insert(table_ans.size(), answer);
  endtask

  task automatic offer(frac_req_t r, bit fixed, frac_res_t answer);
    in_valid_i      <= 1'b1;
    req_type_i      <= r.op;
    a_whole_i       <= r.a_whole;
    a_numerator_i   <= r.a_num;
    a_denominator_i <= r.a_den;
    b_whole_i       <= r.b_whole;
    b_numerator_i   <= r.b_num;
    b_denominator_i <= r.b_den;
    do_reduce_i     <= r.reduce;
    make_mixed_i    <= r.mixed;
    row_fixed       <= fixed;
    row_answer      <= answer;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // transfer took place at this edge; maybe idle for a burst
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  function automatic frac_req_t mk(rau_op_e op, int aw, int an, int ad,
                                   int bw, int bn, int bd, bit red, bit mix);
    frac_req_t r;
    r.op = op;
    r.a_whole = aw[OB-1:0]; r.a_num = an[OB-1:0]; r.a_den = ad[OB-2:0];
    r.b_whole = bw[OB-1:0]; r.b_num = bn[OB-1:0]; r.b_den = bd[OB-2:0];
    r.reduce = red; r.mixed = mix;
    return r;
  endfunction

  function automatic frac_res_t ans(longint w, longint n, longint d, bit z);
    frac_res_t o;
    o.whole = w[OUT_NUM_W-1:0];
    o.num   = n[OUT_NUM_W-1:0];
    o.den   = d[OUT_DEN_W-1:0];
    o.dbz   = z;
    return o;
  endfunction

  // Random operands: mostly full range, sometimes small values so that
  // reduction and mixed splitting produce non-trivial quotients, and a zero
  // second operand now and then for divide.
  function automatic frac_req_t random_req();
    frac_req_t r;
    r.op      = rau_op_e'($urandom_range(0, 3));
    r.a_whole = OB'($urandom); r.a_num = OB'($urandom); r.a_den = (OB-1)'($urandom);
    r.b_whole = OB'($urandom); r.b_num = OB'($urandom); r.b_den = (OB-1)'($urandom);
    r.reduce  = 1'($urandom); r.mixed = 1'($urandom);
    if ($urandom_range(0, 2) == 0) begin
      r.a_whole = OB'($urandom_range(0, 6) - 3); r.a_num = OB'($urandom_range(0, 20) - 10);
      r.a_den   = (OB-1)'($urandom_range(0, 12));
      r.b_whole = OB'($urandom_range(0, 6) - 3); r.b_num = OB'($urandom_range(0, 20) - 10);
      r.b_den   = (OB-1)'($urandom_range(0, 12));
    end
    if ($urandom_range(0, 9) == 0) begin
      r.b_whole = '0;
      r.b_num   = '0;
    end else if ($urandom_range(0, 19) == 0) begin
      // whole and numerator cancel: b is zero though neither field is
      r.b_den   = (OB-1)'($urandom_range(1, 40));
      r.b_whole = OB'($urandom_range(1, 40));
      r.b_num   = -(r.b_whole * r.b_den);
    end
    return r;
  endfunction

  initial begin
    frac_res_t none;
    none = '0;
    calm     = 1'b0;
    hold_req = 1'b0;
    in_valid_i      <= 1'b0;
    req_type_i      <= OP_ADD;
    a_whole_i       <= '0;
    a_numerator_i   <= '0;
    a_denominator_i <= '0;
    b_whole_i       <= '0;
    b_numerator_i   <= '0;
    b_denominator_i <= '0;
    do_reduce_i     <= 1'b0;
    make_mixed_i    <= 1'b0;
    row_fixed       <= 1'b0;
    row_answer      <= '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: typed answers where they are obvious, predictor otherwise.
    add_row(mk(OP_ADD, 0, 0, 1, 0, 0, 1, 1, 0), 1'b1, ans(0, 0, 1, 0));  // 0 + 0 -> 0/1
    add_row(mk(OP_MUL, 1, 0, 1, 1, 0, 1, 0, 0), 1'b1, ans(0, 1, 1, 0));  // 1 * 1
    add_row(mk(OP_DIV, 5, 3, 7, 0, 0, 9, 1, 1), 1'b1, ans(0, 0, 0, 1));  // divide by zero
    add_row(mk(OP_DIV, -2048, -2048, 2047, 3, -6, 2, 0, 0), 1'b1,
            ans(0, 0, 0, 1));                                            // b cancels
    add_row(mk(OP_SUB, 3, 1, 2, 3, 1, 2, 1, 1), 1'b1, ans(0, 0, 1, 0));  // equal -> 0/1
    add_row(mk(OP_ADD, 2047, 2047, 2047, 2047, 2047, 2047, 0, 0));
    add_row(mk(OP_SUB, -2048, -2048, 2047, 2047, 2047, 2046, 1, 1));
    add_row(mk(OP_MUL, -2048, -2048, 2047, -2048, -2048, 2047, 0, 1));
    add_row(mk(OP_MUL, 2047, 2047, 1, -2048, 0, 1, 1, 0));
    add_row(mk(OP_DIV, -2048, 2047, 2047, 0, 1, 2047, 1, 1));
    add_row(mk(OP_DIV, 1, 0, 1, 0, -1, 2047, 0, 0));      // negative divisor
    add_row(mk(OP_ADD, 1, 2, 0, 1, 1, 0, 0, 0));          // zero denominators
    add_row(mk(OP_DIV, 0, 7, 0, 0, -3, 0, 1, 1));
    add_row(mk(OP_SUB, 0, -7, 3, 0, 0, 5, 0, 1));         // negative remainder
    add_row(mk(OP_ADD, 0, 1, 6, 0, 1, 10, 1, 0));         // lcm path
    add_row(mk(OP_MUL, 0, 6, 4, 0, -2, 9, 1, 1));
    add_row(mk(OP_DIV, 0, -9, 4, 0, 3, 8, 0, 1));
    add_row(mk(OP_SUB, 1, 0, 1024, -1, 1023, 1024, 1, 0));
    foreach (table_req[i]) offer(table_req[i], table_fixed[i], table_ans[i]);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) begin
        // stall the result side long enough for the input to back up
        hold_req = 1'b1;
      end
      if (i == 800) begin
        // sender pause until the block has fully drained
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      if (i == N_RANDOM - N_CALM) calm = 1'b1;
      offer(random_req(), 1'b0, none);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("rational_arithmetic_unit regression: pass");
    end else begin
      $display("rational_arithmetic_unit regression: fail");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request, steady at the end.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: log each input transfer, check each result transfer, watchdog.
  // Values read here are the ones present at the edge, since every driver
  // updates through nonblocking assignments.
  // ---------------------------------------------------------------------------
  int stuck_cycles;

  initial begin
    n_errors     = 0;
    stuck_cycles = 0;
  end

  always @(posedge clk_i) begin
    frac_req_t r;
    frac_res_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        r.op = rau_op_e'(req_type_i);
        r.a_whole = a_whole_i; r.a_num = a_numerator_i; r.a_den = a_denominator_i;
        r.b_whole = b_whole_i; r.b_num = b_numerator_i; r.b_den = b_denominator_i;
        r.reduce = do_reduce_i; r.mixed = make_mixed_i;
        pending_results.insert(pending_results.size(),
                               row_fixed ? row_answer : fraction_result(r));
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("%0t: unexpected result transfer whole=%0d num=%0d den=%0d dbz=%0b",
                     $realtime, result_whole_o, result_numerator_o,
                     result_denominator_o, divide_by_zero_o);
        end else begin
          want = pending_results.pop_front();
          if (result_whole_o !== want.whole || result_numerator_o !== want.num ||
              result_denominator_o !== want.den || divide_by_zero_o !== want.dbz) begin
            n_errors++;
            if (n_errors <= 10)
              $display("%0t: mismatch exp %0d %0d/%0d dbz=%0b, got %0d %0d/%0d dbz=%0b",
                       $realtime, want.whole, want.num, want.den, want.dbz,
                       result_whole_o, result_numerator_o, result_denominator_o,
                       divide_by_zero_o);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_MAX) begin
          $display("rational_arithmetic_unit regression: fail");
          $finish;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rational_arithmetic_unit.f]
rtl/rau_pkg.sv
rtl/rau_div.sv
rtl/rational_arithmetic_unit.sv
test/rational_arithmetic_unit_tb.sv
